/* hw/rtl/owm_pkg.sv */
package owm_pkg;

    // Item kind codes
    localparam logic [2:0] KIND_TICK  = 3'd0;
    localparam logic [2:0] KIND_RESET = 3'd1;
    localparam logic [2:0] KIND_WBIT  = 3'd2;
    localparam logic [2:0] KIND_RBIT  = 3'd3;
    localparam logic [2:0] KIND_WBYTE = 3'd4;
    localparam logic [2:0] KIND_RWORD = 3'd5;

    // Configuration register indexes
    localparam logic [2:0] REG_RESET_LOW   = 3'd0;
    localparam logic [2:0] REG_PRES_WAIT   = 3'd1;
    localparam logic [2:0] REG_RESET_TAIL  = 3'd2;
    localparam logic [2:0] REG_SLOT_LOW    = 3'd3;
    localparam logic [2:0] REG_READ_WAIT   = 3'd4;
    localparam logic [2:0] REG_READ_TAIL   = 3'd5;
    localparam logic [2:0] REG_WRITE_HOLD  = 3'd6;
    localparam logic [2:0] REG_RECOVERY    = 3'd7;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 10;
    localparam int TIMER_W    = 10;
    localparam int COUNT_W    = 5;
    localparam int SHIFT_W    = 16;

    // Bits per multi-bit operation
    localparam int OWM_WRITE_BITS = 8;
    localparam int OWM_READ_BITS  = 16;

    typedef enum logic [3:0] {
        PH_IDLE      = 4'd0,
        PH_RST_LOW   = 4'd1,
        PH_RST_WAIT  = 4'd2,
        PH_RST_TAIL  = 4'd3,
        PH_SLOT_LOW  = 4'd4,
        PH_READ_WAIT = 4'd5,
        PH_READ_TAIL = 4'd6,
        PH_WR_HOLD   = 4'd7,
        PH_RECOVER   = 4'd8
    } t_phase;

    typedef struct packed {
        logic [9:0] reset_low_time;
        logic [9:0] presence_wait;
        logic [9:0] reset_tail;
        logic [5:0] slot_start_low;
        logic [5:0] read_sample_wait;
        logic [9:0] read_tail;
        logic [7:0] write_hold;
        logic [7:0] recovery_time;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        reset_low_time:   10'd480,
        presence_wait:    10'd100,
        reset_tail:       10'd380,
        slot_start_low:   6'd2,
        read_sample_wait: 6'd10,
        read_tail:        10'd429,
        write_hold:       8'd58,
        recovery_time:    8'd10
    };

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] data;
        logic       line_level;
    } t_item;

    typedef struct packed {
        logic        drive_low;
        logic        busy_res;
        logic        done_res;
        logic        presence;
        logic [15:0] read_word;
        logic        read_bit;
        logic        rejected;
    } t_result;

endpackage

/* hw/rtl/owm_cfg_regs.sv */
module owm_cfg_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [owm_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [owm_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output owm_pkg::t_cfg                  o_cfg
);

    owm_pkg::t_cfg r_cfg;

    // Timing registers, each keeps only its own width of the write data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= owm_pkg::CFG_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                owm_pkg::REG_RESET_LOW:  r_cfg.reset_low_time   <= i_cfg_data;
                owm_pkg::REG_PRES_WAIT:  r_cfg.presence_wait    <= i_cfg_data;
                owm_pkg::REG_RESET_TAIL: r_cfg.reset_tail       <= i_cfg_data;
                owm_pkg::REG_SLOT_LOW:   r_cfg.slot_start_low   <= i_cfg_data[5:0];
                owm_pkg::REG_READ_WAIT:  r_cfg.read_sample_wait <= i_cfg_data[5:0];
                owm_pkg::REG_READ_TAIL:  r_cfg.read_tail        <= i_cfg_data;
                owm_pkg::REG_WRITE_HOLD: r_cfg.write_hold       <= i_cfg_data[7:0];
                owm_pkg::REG_RECOVERY:   r_cfg.recovery_time    <= i_cfg_data[7:0];
                default:                 r_cfg                  <= r_cfg;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

/* hw/rtl/owm_engine.sv */
module owm_engine #(
    parameter int WRITE_BITS = owm_pkg::OWM_WRITE_BITS,
    parameter int READ_BITS  = owm_pkg::OWM_READ_BITS
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  owm_pkg::t_item   i_item,
    input  owm_pkg::t_cfg    i_cfg,
    output owm_pkg::t_result o_res
);

    localparam logic [owm_pkg::COUNT_W-1:0] WriteTarget = owm_pkg::COUNT_W'(WRITE_BITS);
    localparam logic [owm_pkg::COUNT_W-1:0] ReadTarget  = owm_pkg::COUNT_W'(READ_BITS);

    owm_pkg::t_phase                 r_phase,     n_phase;
    logic [owm_pkg::TIMER_W-1:0]     r_timer,     n_timer;
    logic [owm_pkg::COUNT_W-1:0]     r_bit_count, n_bit_count;
    logic [owm_pkg::SHIFT_W-1:0]     r_shift,     n_shift;
    logic                            r_presence,  n_presence;
    logic [2:0]                      r_op_kind,   n_op_kind;

    logic                            w_busy;
    logic                            w_is_cmd;
    logic                            w_done;
    logic                            w_rej;
    logic                            w_op_read;
    logic                            w_n_read;
    logic [owm_pkg::TIMER_W-1:0]     w_timer_inc;
    logic [owm_pkg::TIMER_W-1:0]     w_len;
    logic [owm_pkg::COUNT_W-1:0]     w_cnt_inc;
    logic [owm_pkg::COUNT_W-1:0]     w_target;
    logic                            w_slot_last;

    assign w_busy      = (r_phase != owm_pkg::PH_IDLE);
    assign w_timer_inc = r_timer + owm_pkg::TIMER_W'(1);
    assign w_cnt_inc   = r_bit_count + owm_pkg::COUNT_W'(1);
    assign w_op_read   = (r_op_kind == owm_pkg::KIND_RBIT) || (r_op_kind == owm_pkg::KIND_RWORD);
    assign w_slot_last = (w_cnt_inc >= w_target);

    // Command decode: unknown codes behave as ticks
    always_comb begin
        unique case (i_item.kind) inside
            owm_pkg::KIND_RESET, owm_pkg::KIND_WBIT, owm_pkg::KIND_RBIT,
            owm_pkg::KIND_WBYTE, owm_pkg::KIND_RWORD: w_is_cmd = 1'b1;
            default:                                  w_is_cmd = 1'b0;
        endcase
    end

    // Bits per operation
    always_comb begin
        case (r_op_kind)
            owm_pkg::KIND_WBYTE: w_target = WriteTarget;
            owm_pkg::KIND_RWORD: w_target = ReadTarget;
            default:             w_target = owm_pkg::COUNT_W'(1);
        endcase
    end

    // Length of the current phase in ticks
    always_comb begin
        unique case (r_phase)
            owm_pkg::PH_RST_LOW:   w_len = i_cfg.reset_low_time;
            owm_pkg::PH_RST_WAIT:  w_len = i_cfg.presence_wait;
            owm_pkg::PH_RST_TAIL:  w_len = i_cfg.reset_tail;
            owm_pkg::PH_SLOT_LOW:  w_len = owm_pkg::TIMER_W'(i_cfg.slot_start_low);
            owm_pkg::PH_READ_WAIT: w_len = owm_pkg::TIMER_W'(i_cfg.read_sample_wait);
            owm_pkg::PH_READ_TAIL: w_len = i_cfg.read_tail;
            owm_pkg::PH_WR_HOLD:   w_len = owm_pkg::TIMER_W'(i_cfg.write_hold);
            default:               w_len = owm_pkg::TIMER_W'(i_cfg.recovery_time);
        endcase
    end

    // Next state for one beat
    always_comb begin
        n_phase     = r_phase;
        n_timer     = r_timer;
        n_bit_count = r_bit_count;
        n_shift     = r_shift;
        n_presence  = r_presence;
        n_op_kind   = r_op_kind;
        w_done      = 1'b0;
        w_rej       = 1'b0;
        if (!w_is_cmd) begin
            if (w_busy) begin
                n_timer = w_timer_inc;
                if (w_timer_inc >= w_len) begin
                    n_timer = '0;
                    unique case (r_phase) inside
                        owm_pkg::PH_RST_LOW: begin
                            n_phase = owm_pkg::PH_RST_WAIT;
                        end
                        owm_pkg::PH_RST_WAIT: begin
                            n_presence = !i_item.line_level;
                            if (i_cfg.reset_tail == '0) begin
                                n_phase = owm_pkg::PH_IDLE;
                                w_done  = 1'b1;
                            end else begin
                                n_phase = owm_pkg::PH_RST_TAIL;
                            end
                        end
                        owm_pkg::PH_RST_TAIL: begin
                            n_phase = owm_pkg::PH_IDLE;
                            w_done  = 1'b1;
                        end
                        owm_pkg::PH_SLOT_LOW: begin
                            n_phase = w_op_read ? owm_pkg::PH_READ_WAIT : owm_pkg::PH_WR_HOLD;
                        end
                        owm_pkg::PH_READ_WAIT: begin
                            n_shift = {i_item.line_level, r_shift[owm_pkg::SHIFT_W-1:1]};
                            if (i_cfg.read_tail == '0) begin
                                n_bit_count = w_cnt_inc;
                                n_phase     = w_slot_last ? owm_pkg::PH_IDLE
                                                          : owm_pkg::PH_SLOT_LOW;
                                w_done      = w_slot_last;
                            end else begin
                                n_phase = owm_pkg::PH_READ_TAIL;
                            end
                        end
                        owm_pkg::PH_WR_HOLD: begin
                            n_shift = {1'b0, r_shift[owm_pkg::SHIFT_W-1:1]};
                            if (i_cfg.recovery_time == '0) begin
                                n_bit_count = w_cnt_inc;
                                n_phase     = w_slot_last ? owm_pkg::PH_IDLE
                                                          : owm_pkg::PH_SLOT_LOW;
                                w_done      = w_slot_last;
                            end else begin
                                n_phase = owm_pkg::PH_RECOVER;
                            end
                        end
                        owm_pkg::PH_READ_TAIL, owm_pkg::PH_RECOVER: begin
                            n_bit_count = w_cnt_inc;
                            n_phase     = w_slot_last ? owm_pkg::PH_IDLE
                                                      : owm_pkg::PH_SLOT_LOW;
                            w_done      = w_slot_last;
                        end
                        default: begin
                            n_phase = owm_pkg::PH_IDLE;
                        end
                    endcase
                end
            end
        end else if (w_busy) begin
            w_rej = 1'b1;
        end else begin
            // Start a new operation with the bus pulled low
            n_op_kind   = i_item.kind;
            n_bit_count = '0;
            n_timer     = '0;
            if (i_item.kind == owm_pkg::KIND_RESET) begin
                n_phase = owm_pkg::PH_RST_LOW;
            end else begin
                n_phase = owm_pkg::PH_SLOT_LOW;
                if (i_item.kind == owm_pkg::KIND_WBIT) begin
                    n_shift = {{(owm_pkg::SHIFT_W-1){1'b0}}, i_item.data[0]};
                end else if (i_item.kind == owm_pkg::KIND_WBYTE) begin
                    n_shift = {{(owm_pkg::SHIFT_W-8){1'b0}}, i_item.data};
                end else if (i_item.kind == owm_pkg::KIND_RWORD) begin
                    n_shift = '0;
                end
            end
        end
    end

    // Result of the beat, taken from the state it leaves behind
    assign w_n_read = (n_op_kind == owm_pkg::KIND_RBIT) || (n_op_kind == owm_pkg::KIND_RWORD);

    always_comb begin
        unique case (n_phase) inside
            owm_pkg::PH_RST_LOW, owm_pkg::PH_SLOT_LOW: o_res.drive_low = 1'b1;
            owm_pkg::PH_WR_HOLD:                       o_res.drive_low = !n_shift[0];
            default:                                   o_res.drive_low = 1'b0;
        endcase
        o_res.busy_res  = (n_phase != owm_pkg::PH_IDLE);
        o_res.done_res  = w_done;
        o_res.presence  = n_presence;
        o_res.read_word = w_n_read ? n_shift : '0;
        o_res.read_bit  = w_n_read ? n_shift[owm_pkg::SHIFT_W-1] : 1'b0;
        o_res.rejected  = w_rej;
    end

    // State advances once per beat that leaves the input stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= owm_pkg::PH_IDLE;
            r_timer     <= '0;
            r_bit_count <= '0;
            r_shift     <= '0;
            r_presence  <= 1'b0;
            r_op_kind   <= '0;
        end else if (i_step) begin
            r_phase     <= n_phase;
            r_timer     <= n_timer;
            r_bit_count <= n_bit_count;
            r_shift     <= n_shift;
            r_presence  <= n_presence;
            r_op_kind   <= n_op_kind;
        end
    end

    // Checks
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> (r_phase == owm_pkg::PH_IDLE) && (r_op_kind == '0))
        else $error("phase not idle after reset");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && w_done) |=> (r_phase == owm_pkg::PH_IDLE))
        else $error("done pulse without return to idle");

    a_reject_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && w_rej) |=> (r_phase == $past(r_phase)) && (r_timer == $past(r_timer)))
        else $error("rejected command changed the phase or timer");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bit_count <= owm_pkg::COUNT_W'(owm_pkg::SHIFT_W))
        else $error("bit counter beyond word length");

endmodule

/* hw/rtl/one_wire_bus_master_core.sv */
// Channel | Signals                                         | Direction
// --------+-------------------------------------------------+----------
// in      | i_in_valid, o_in_ready, i_kind, i_data,         | to core
//         | i_line_level                                    |
// out     | o_out_valid, i_out_ready, o_drive_low, o_busy_res,| from core
//         | o_done_res, o_presence, o_read_word, o_read_bit,|
//         | o_rejected                                      |
// cfg     | i_cfg_we, i_cfg_index, i_cfg_data               | to core
//
// One beat per cycle while the output is not stalled; each beat goes through the input
// register, then the result register after the step logic.
// The phase state updates as a beat moves from the input to the result register.
// Synchronous active-low reset clears state and valids, presets timing registers.
// A stalled output holds its result and the input register holds one beat.
module one_wire_bus_master_core #(
    parameter int WRITE_BITS = owm_pkg::OWM_WRITE_BITS,
    parameter int READ_BITS  = owm_pkg::OWM_READ_BITS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [2:0]                     i_kind,
    input  logic [7:0]                     i_data,
    input  logic                           i_line_level,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic                           o_drive_low,
    output logic                           o_busy_res,
    output logic                           o_done_res,
    output logic                           o_presence,
    output logic [15:0]                    o_read_word,
    output logic                           o_read_bit,
    output logic                           o_rejected,
    input  logic                           i_cfg_we,
    input  logic [owm_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [owm_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    owm_pkg::t_cfg    w_cfg;
    owm_pkg::t_item   r_in;
    owm_pkg::t_result w_res;
    owm_pkg::t_result r_out;
    logic             r_in_valid;
    logic             r_out_valid;
    logic             w_move;

    owm_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    owm_engine #(
        .WRITE_BITS (WRITE_BITS),
        .READ_BITS  (READ_BITS)
    ) u_engine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_move),
        .i_item  (r_in),
        .i_cfg   (w_cfg),
        .o_res   (w_res)
    );

    // Beat moves on when the result register is free or being emptied
    assign w_move     = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_move;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (w_move) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in <= '{kind: i_kind, data: i_data, line_level: i_line_level};
        end
        if (w_move) begin
            r_out <= w_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_drive_low = r_out.drive_low;
    assign o_busy_res  = r_out.busy_res;
    assign o_done_res  = r_out.done_res;
    assign o_presence  = r_out.presence;
    assign o_read_word = r_out.read_word;
    assign o_read_bit  = r_out.read_bit;
    assign o_rejected  = r_out.rejected;

endmodule

/* tb/one_wire_master_checker.sv */
`timescale 1ns / 100ps

// Watches the command and result channels of the 1-Wire master, keeps its own
// copy of the bus-master state and timing registers, and checks every result beat.
module one_wire_master_checker
    import owm_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    input  logic                    i_in_ready,
    input  t_item                   i_item,
    input  logic                    i_out_valid,
    input  logic                    i_out_ready,
    input  t_result                 i_result,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [CFG_DATA_W-1:0]   i_cfg_data,
    output int                      o_mismatches,
    output int                      o_pending,
    output logic                    o_bus_busy
);

    // Predicted bus-master state
    t_cfg          timing;
    t_phase        phase;
    logic [9:0]    slot_timer;
    logic [4:0]    bit_count;
    logic [15:0]   shift_reg;
    logic          presence_flag;
    logic [2:0]    op_kind;
    logic          completed;

    t_result       expected_results[$];
    int            mismatch_count = 0;
    int            pending_count  = 0;
    int            results_seen   = 0;

    assign o_mismatches = mismatch_count;
    assign o_pending    = pending_count;
    assign o_bus_busy   = (phase != PH_IDLE);

    task automatic report_mismatch(input string what);
        mismatch_count++;
        $display("[%0t] mismatch on result %0d: %s", $time, results_seen, what);
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want) begin
            report_mismatch($sformatf("%s expected %0h, got %0h", name, want, got));
        end
    endtask

    function automatic logic read_in_progress();
        return (op_kind == KIND_RBIT) || (op_kind == KIND_RWORD);
    endfunction

    function automatic void enter_phase(input t_phase next_phase);
        phase      = next_phase;
        slot_timer = '0;
    endfunction

    function automatic void finish_operation();
        enter_phase(PH_IDLE);
        completed = 1'b1;
    endfunction

    // End of one bit slot: either the operation is complete or the next slot opens
    function automatic void close_slot();
        int target;
        target = 1;
        if (op_kind == KIND_WBYTE) begin
            target = OWM_WRITE_BITS;
        end else if (op_kind == KIND_RWORD) begin
            target = OWM_READ_BITS;
        end
        bit_count = bit_count + 5'd1;
        if (int'(bit_count) >= target) begin
            finish_operation();
        end else begin
            enter_phase(PH_SLOT_LOW);
        end
    endfunction

    // Advance the predicted state by one beat and return the result it yields
    function automatic t_result step_bus_master(input t_item it);
        t_result    r;
        logic [9:0] limit;
        logic       busy_in;
        r         = '0;
        completed = 1'b0;
        busy_in   = (phase != PH_IDLE);

        if (it.kind == KIND_TICK || it.kind > KIND_RWORD) begin
            if (busy_in) begin
                slot_timer = slot_timer + 10'd1;
                case (phase)
                    PH_RST_LOW:   limit = timing.reset_low_time;
                    PH_RST_WAIT:  limit = timing.presence_wait;
                    PH_RST_TAIL:  limit = timing.reset_tail;
                    PH_SLOT_LOW:  limit = {4'd0, timing.slot_start_low};
                    PH_READ_WAIT: limit = {4'd0, timing.read_sample_wait};
                    PH_READ_TAIL: limit = timing.read_tail;
                    PH_WR_HOLD:   limit = {2'd0, timing.write_hold};
                    default:      limit = {2'd0, timing.recovery_time};
                endcase
                if (slot_timer >= limit) begin
                    case (phase)
                        PH_RST_LOW: enter_phase(PH_RST_WAIT);
                        PH_RST_WAIT: begin
                            presence_flag = ~it.line_level;
                            if (timing.reset_tail == '0) finish_operation();
                            else enter_phase(PH_RST_TAIL);
                        end
                        PH_RST_TAIL: finish_operation();
                        PH_SLOT_LOW: begin
                            enter_phase(read_in_progress() ? PH_READ_WAIT : PH_WR_HOLD);
                        end
                        PH_READ_WAIT: begin
                            shift_reg = {it.line_level, shift_reg[15:1]};
                            if (timing.read_tail == '0) close_slot();
                            else enter_phase(PH_READ_TAIL);
                        end
                        PH_READ_TAIL: close_slot();
                        PH_WR_HOLD: begin
                            shift_reg = shift_reg >> 1;
                            if (timing.recovery_time == '0) close_slot();
                            else enter_phase(PH_RECOVER);
                        end
                        PH_RECOVER: close_slot();
                        default: enter_phase(PH_IDLE);
                    endcase
                end
            end
        end else if (busy_in) begin
            // command while an operation runs: dropped and flagged
            r.rejected = 1'b1;
        end else begin
            op_kind   = it.kind;
            bit_count = '0;
            if (it.kind == KIND_RESET) begin
                enter_phase(PH_RST_LOW);
            end else begin
                if (it.kind == KIND_WBIT) shift_reg = {15'd0, it.data[0]};
                else if (it.kind == KIND_WBYTE) shift_reg = {8'd0, it.data};
                else if (it.kind == KIND_RWORD) shift_reg = '0;
                enter_phase(PH_SLOT_LOW);
            end
        end

        if (phase == PH_RST_LOW || phase == PH_SLOT_LOW) begin
            r.drive_low = 1'b1;
        end else if (phase == PH_WR_HOLD) begin
            r.drive_low = ~shift_reg[0];
        end
        r.busy_res  = (phase != PH_IDLE);
        r.done_res  = completed;
        r.presence  = presence_flag;
        r.read_word = read_in_progress() ? shift_reg : 16'd0;
        r.read_bit  = read_in_progress() ? shift_reg[15] : 1'b0;
        return r;
    endfunction

    // Track config writes, predict on input beats, compare on output beats
    always @(posedge i_clk) begin : monitor
        t_result want;
        if (!i_rst_n) begin
            timing        = CFG_RESET;
            phase         = PH_IDLE;
            slot_timer    = '0;
            bit_count     = '0;
            shift_reg     = '0;
            presence_flag = 1'b0;
            op_kind       = '0;
            completed     = 1'b0;
            expected_results.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_RESET_LOW:  timing.reset_low_time   = i_cfg_data;
                    REG_PRES_WAIT:  timing.presence_wait    = i_cfg_data;
                    REG_RESET_TAIL: timing.reset_tail       = i_cfg_data;
                    REG_SLOT_LOW:   timing.slot_start_low   = i_cfg_data[5:0];
                    REG_READ_WAIT:  timing.read_sample_wait = i_cfg_data[5:0];
                    REG_READ_TAIL:  timing.read_tail        = i_cfg_data;
                    REG_WRITE_HOLD: timing.write_hold       = i_cfg_data[7:0];
                    default:        timing.recovery_time    = i_cfg_data[7:0];
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("result beat with nothing expected");
                end else begin
                    want = expected_results.pop_front();
                    check_field("drive_low", want.drive_low, i_result.drive_low);
                    check_field("busy_res", want.busy_res, i_result.busy_res);
                    check_field("done_res", want.done_res, i_result.done_res);
                    check_field("presence", want.presence, i_result.presence);
                    check_field("read_word", want.read_word, i_result.read_word);
                    check_field("read_bit", want.read_bit, i_result.read_bit);
                    check_field("rejected", want.rejected, i_result.rejected);
                end
                results_seen++;
            end
            if (i_in_valid && i_in_ready) begin
                expected_results.push_back(step_bus_master(i_item));
            end
        end
        pending_count = expected_results.size();
    end

endmodule

/* tb/one_wire_bus_master_core_test.sv */
`timescale 1ns / 100ps

module one_wire_bus_master_core_test;
    import owm_pkg::*;

    // Kinds outside the command set; the core treats them as ticks
    localparam logic [2:0] KIND_SPARE6 = 3'd6;
    localparam logic [2:0] KIND_SPARE7 = 3'd7;

    // Bus level patterns fed on ticks
    localparam int LINE_LOW    = 0;
    localparam int LINE_HIGH   = 1;
    localparam int LINE_RANDOM = 2;

    localparam int HOLDOFF_CYCLES = 200;
    localparam int STALL_LIMIT    = 2000;
    localparam int DRAIN_CYCLES   = 4;
    localparam int ITEM_TARGET    = 900;
    localparam int RANDOM_PHASES  = 6;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [2:0]  in_kind = KIND_TICK;
    logic [7:0]  in_data = 8'd0;
    logic        in_line = 1'b1;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic        drive_low, busy_res, done_res, presence, read_bit, rejected;
    logic [15:0] read_word;
    logic        cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = REG_RESET_LOW;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    int          mismatches;
    int          pending;
    logic        bus_busy;
    logic        calm = 1'b0;
    int          hold_requests = 0;
    int          beats_sent = 0;

    one_wire_bus_master_core u_top (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .o_in_ready   (in_ready),
        .i_kind       (in_kind),
        .i_data       (in_data),
        .i_line_level (in_line),
        .o_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .o_drive_low  (drive_low),
        .o_busy_res   (busy_res),
        .o_done_res   (done_res),
        .o_presence   (presence),
        .o_read_word  (read_word),
        .o_read_bit   (read_bit),
        .o_rejected   (rejected),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data)
    );

    one_wire_master_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_item       ({in_kind, in_data, in_line}),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_result     ({drive_low, busy_res, done_res, presence, read_word,
                        read_bit, rejected}),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_mismatches (mismatches),
        .o_pending    (pending),
        .o_bus_busy   (bus_busy)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    // Result side: random back-pressure, plus one long hold-off on request
    initial begin
        int hold_left;
        int holds_served;
        hold_left    = 0;
        holds_served = 0;
        forever begin
            @(negedge clk);
            if (hold_requests != holds_served) begin
                holds_served = hold_requests;
                hold_left    = HOLDOFF_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ready <= 1'b0;
            end else begin
                out_ready <= calm || ($urandom_range(99) >= 7);
            end
        end
    end

    // Watchdog: too many cycles with no beat on either channel
    initial begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT) begin
            @(posedge clk);
            if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
        end
        $display("TEST FAILED");
        $finish;
    end

    function automatic logic pick_line(input int mode);
        if (mode == LINE_RANDOM) return 1'($urandom_range(1));
        return (mode == LINE_HIGH);
    endfunction

    // Offer one beat and return at the falling edge after it is taken
    task automatic send_beat(input logic [2:0] k, input logic [7:0] d, input logic l);
        int gap;
        if (!calm && $urandom_range(99) < 7) begin
            gap = $urandom_range(1, 4);
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_kind  <= k;
        in_data  <= d;
        in_line  <= l;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        beats_sent++;
        @(negedge clk);
    endtask

    // Tick the running operation to completion, optionally mixing in stray beats
    task automatic tick_until_idle(input int mode, input bit noisy);
        int roll;
        while (bus_busy) begin
            roll = $urandom_range(99);
            if (noisy && roll < 4) begin
                send_beat(3'($urandom_range(KIND_RESET, KIND_RWORD)), 8'($urandom),
                          pick_line(mode));
            end else if (noisy && roll < 8) begin
                send_beat(roll[0] ? KIND_SPARE7 : KIND_SPARE6, 8'($urandom),
                          pick_line(mode));
            end else begin
                send_beat(KIND_TICK, 8'($urandom), pick_line(mode));
            end
        end
    endtask

    task automatic run_command(input logic [2:0] k, input logic [7:0] d,
                               input int mode, input bit noisy);
        send_beat(k, d, pick_line(mode));
        tick_until_idle(mode, noisy);
    endtask

    // Stop offering and let every outstanding result come back
    task automatic wait_all_results();
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [9:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
    endtask

    // Timing registers change only with the core idle
    task automatic load_timing(input t_cfg c);
        wait_all_results();
        put_reg(REG_RESET_LOW, c.reset_low_time);
        put_reg(REG_PRES_WAIT, c.presence_wait);
        put_reg(REG_RESET_TAIL, c.reset_tail);
        put_reg(REG_SLOT_LOW, {4'd0, c.slot_start_low});
        put_reg(REG_READ_WAIT, {4'd0, c.read_sample_wait});
        put_reg(REG_READ_TAIL, c.read_tail);
        put_reg(REG_WRITE_HOLD, {2'd0, c.write_hold});
        put_reg(REG_RECOVERY, {2'd0, c.recovery_time});
        cfg_we <= 1'b0;
    endtask

    function automatic t_cfg random_timing();
        t_cfg c;
        c.reset_low_time   = 10'($urandom_range(1, 8));
        c.presence_wait    = 10'($urandom_range(1, 6));
        c.reset_tail       = 10'($urandom_range(0, 4));
        c.slot_start_low   = 6'($urandom_range(1, 3));
        c.read_sample_wait = 6'($urandom_range(1, 4));
        c.read_tail        = 10'($urandom_range(0, 4));
        c.write_hold       = 8'($urandom_range(1, 5));
        c.recovery_time    = 8'($urandom_range(0, 3));
        return c;
    endfunction

    // Stimulus
    initial begin
        t_cfg short_timing;
        int   phase_no;
        int   mode;
        int   noise;
        int   random_start;
        int   per_phase;

        short_timing = '{reset_low_time: 10'd3, presence_wait: 10'd2, reset_tail: 10'd2,
                         slot_start_low: 6'd1, read_sample_wait: 6'd2, read_tail: 10'd1,
                         write_hold: 8'd3, recovery_time: 8'd1};

        repeat (7) @(negedge clk);
        rst_n <= 1'b1;

        // Write slot with the timing registers at their reset values
        run_command(KIND_WBIT, 8'h01, LINE_RANDOM, 1'b0);

        // Short slots: every command, a reset with no presence answer, data extremes
        load_timing(short_timing);
        run_command(KIND_RESET, 8'hFF, LINE_HIGH, 1'b0);
        run_command(KIND_WBIT, 8'hFE, LINE_RANDOM, 1'b0);
        run_command(KIND_WBYTE, 8'h00, LINE_RANDOM, 1'b0);
        run_command(KIND_WBYTE, 8'hFF, LINE_RANDOM, 1'b0);
        run_command(KIND_RBIT, 8'h00, LINE_HIGH, 1'b0);
        run_command(KIND_RBIT, 8'hFF, LINE_LOW, 1'b0);
        run_command(KIND_RWORD, 8'h00, LINE_HIGH, 1'b0);
        run_command(KIND_RWORD, 8'hFF, LINE_LOW, 1'b0);

        // Commands and spare kinds arriving mid-operation
        send_beat(KIND_WBYTE, 8'hA5, 1'b0);
        send_beat(KIND_TICK, 8'h00, 1'b1);
        send_beat(KIND_RWORD, 8'h3C, 1'b1);
        send_beat(KIND_RESET, 8'h00, 1'b0);
        send_beat(KIND_SPARE6, 8'h81, 1'b1);
        send_beat(KIND_SPARE7, 8'h7E, 1'b0);
        tick_until_idle(LINE_RANDOM, 1'b0);

        // Ticks with nothing running are ignored
        send_beat(KIND_TICK, 8'h00, 1'b0);
        send_beat(KIND_SPARE7, 8'hFF, 1'b1);
        send_beat(KIND_SPARE6, 8'h55, 1'b0);

        // All timing registers zero: one-tick phases, tails and recovery skipped
        load_timing('0);
        run_command(KIND_RESET, 8'h00, LINE_LOW, 1'b0);
        run_command(KIND_RBIT, 8'h00, LINE_RANDOM, 1'b0);
        run_command(KIND_WBYTE, 8'h5A, LINE_RANDOM, 1'b0);
        run_command(KIND_RWORD, 8'h00, LINE_RANDOM, 1'b0);

        // Random operations under several random timing settings
        random_start = beats_sent;
        per_phase    = (ITEM_TARGET - random_start) / RANDOM_PHASES;
        for (phase_no = 0; phase_no < RANDOM_PHASES; phase_no++) begin
            load_timing(random_timing());
            calm <= (phase_no == 1);
            if (phase_no == 2) hold_requests <= hold_requests + 1;
            while (beats_sent < random_start + (phase_no + 1) * per_phase) begin
                mode = $urandom_range(LINE_LOW, LINE_RANDOM + 1);
                if (mode > LINE_RANDOM) mode = LINE_RANDOM;
                run_command(3'($urandom_range(KIND_RESET, KIND_RWORD)), 8'($urandom),
                            mode, 1'b1);
                noise = $urandom_range(0, 2);
                repeat (noise) begin
                    send_beat(3'($urandom_range(0, 1)) == 3'd0 ? KIND_TICK : KIND_SPARE6,
                              8'($urandom), 1'($urandom_range(1)));
                end
            end
        end

        wait_all_results();
        if (mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
